// ===== rtl/urc_pkg.sv =====
// Package for the ultrasonic range controller: widths, constants, codes and microcode.
package urc_pkg;

	// Field widths
	localparam int COUNTER_BITS_DEF = 16;
	localparam int TICKS_W          = 8;
	localparam int DIST_W           = 24;
	localparam int TEMP_W           = 8;
	localparam int HUM_W            = 7;
	localparam int FACTOR_W         = 22;
	localparam int REM_W            = 15;
	localparam int IDX_W            = 2;
	localparam int IN_DATA_W        = 24;
	localparam int OUT_DATA_W       = 32;

	// Speed of sound factor: 3313000 + 6060*T + 124*H, distance = width*factor/20000
	localparam int SOUND_BASE = 3313000;
	localparam int TEMP_COEF  = 6060;
	localparam int HUM_COEF   = 124;
	localparam int DIV_CONST  = 20000;

	// Division by 20000: shift right by 5, then multiply by the reciprocal of 625
	// and shift right by 41; exact for every product below the saturation limit
	localparam int              PRE_SHIFT   = 5;
	localparam int              RECIP_W     = 32;
	localparam int              RECIP_SHIFT = 41;
	localparam logic [RECIP_W-1:0] RECIP_625 = 32'd3518437209;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	// Smallest product whose quotient no longer fits the distance field
	localparam logic [63:0] SAT_LIMIT = 64'(DIV_CONST) << DIST_W;

	// Reset values of the registers
	localparam logic [TICKS_W-1:0] TRIG_TICKS_RST = 8'd11;
	localparam logic [DIST_W-1:0]  MIN_DIST_RST   = 24'd20000;
	localparam logic [DIST_W-1:0]  MAX_DIST_RST   = 24'd4000000;

	// Register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_TRIGGER_TICKS = 2'd0,
		REG_MIN_DISTANCE  = 2'd1,
		REG_MAX_DISTANCE  = 2'd2
	} reg_idx_t;

	// Measurement phase
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TRIG = 2'd1,
		PH_WAIT = 2'd2
	} phase_t;

	// Microcode
	localparam int STEP_W = 3;

	typedef enum logic [2:0] {
		OP_FETCH = 3'd0,
		OP_MUL   = 3'd1,
		OP_SAT   = 3'd2,
		OP_RLO   = 3'd3,
		OP_RHI   = 3'd4,
		OP_EMIT  = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		C_NONE      = 3'd0,
		C_NO_ACCEPT = 3'd1,
		C_NO_DONE   = 3'd2,
		C_SAT       = 3'd3,
		C_OUT_FULL  = 3'd4
	} cond_t;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [STEP_W-1:0] target;
		logic             last;
	} ctl_word_t;

	localparam logic [STEP_W-1:0] STEP_FETCH = 3'd0;
	localparam logic [STEP_W-1:0] STEP_MUL   = 3'd1;
	localparam logic [STEP_W-1:0] STEP_SAT   = 3'd2;
	localparam logic [STEP_W-1:0] STEP_RLO   = 3'd3;
	localparam logic [STEP_W-1:0] STEP_RHI   = 3'd4;
	localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd5;

	// Program: jump to target when the condition holds, else fall through, or return to fetch after the last step
	function automatic ctl_word_t ucode_rom(input logic [STEP_W-1:0] step);
		ctl_word_t w;
		case (step)
			STEP_FETCH: w = '{op: OP_FETCH, cond: C_NO_ACCEPT, target: STEP_FETCH, last: 1'b0};
			STEP_MUL:   w = '{op: OP_MUL,   cond: C_NO_DONE,   target: STEP_EMIT,  last: 1'b0};
			STEP_SAT:   w = '{op: OP_SAT,   cond: C_SAT,       target: STEP_EMIT,  last: 1'b0};
			STEP_RLO:   w = '{op: OP_RLO,   cond: C_NONE,      target: STEP_RHI,   last: 1'b0};
			STEP_RHI:   w = '{op: OP_RHI,   cond: C_NONE,      target: STEP_EMIT,  last: 1'b0};
			STEP_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_FULL,  target: STEP_EMIT,  last: 1'b1};
			default:    w = '{op: OP_EMIT,  cond: C_NONE,      target: STEP_FETCH, last: 1'b1};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/ultrasonic_range_controller.sv =====
// Ultrasonic range controller: trigger timing, echo width capture and distance sequencer.
//
// channel | dir | handshake                      | payload
// s_axis  | in  | s_axis_tvalid / s_axis_tready  | one microsecond tick
// m_axis  | out | m_axis_tvalid / m_axis_tready  | one status/result per tick
// cfg     | in  | cfg_valid / cfg_ready          | register index and data
//
// A tick with no distance runs fetch, multiply and emit; a tick that delivers a
// distance runs fetch, multiply, saturation check, two reciprocal multiply steps
// and emit, and skips the reciprocal steps if the distance saturates. The divide by
// 20000 is a shift and a 32-bit reciprocal multiply split into two 17x32 halves.
// Ticks are taken only in the fetch step. The emit step holds while the output
// register is full; a new tick is taken as soon as the result is registered.
// Reset is asynchronous and active low; the configuration port is always ready.
module ultrasonic_range_controller #(
	parameter int COUNTER_BITS = urc_pkg::COUNTER_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// tdata: start_req[0], echo_level[1], temperature_c[9:2], humidity_pct[16:10], zeros
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [urc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// tdata: trigger_level[0], busy_res[1], done_res[2], distance_um[26:3],
	//        in_range[27], zeros
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [urc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [urc_pkg::IDX_W-1:0]       cfg_index,
	input  logic [urc_pkg::DIST_W-1:0]      cfg_data
);

	localparam int PROD_W    = COUNTER_BITS + urc_pkg::FACTOR_W;
	localparam int SAT_W     = urc_pkg::REM_W + urc_pkg::DIST_W;
	localparam int CMP_W     = (PROD_W > SAT_W) ? PROD_W : SAT_W;
	localparam int X_W       = SAT_W - urc_pkg::PRE_SHIFT;
	localparam int LO_W      = X_W / 2;
	localparam int HI_W      = X_W - LO_W;
	localparam int LO_PROD_W = LO_W + urc_pkg::RECIP_W;
	localparam int SUM_W     = HI_W + urc_pkg::RECIP_W + 1;
	localparam int QSH       = urc_pkg::RECIP_SHIFT - LO_W;

	// Configuration
	logic [urc_pkg::TICKS_W-1:0] trig_ticks_q;
	logic [urc_pkg::DIST_W-1:0]  min_dist_q;
	logic [urc_pkg::DIST_W-1:0]  max_dist_q;

	// Tick state
	logic [COUNTER_BITS-1:0] free_cnt_q;
	logic [COUNTER_BITS-1:0] trig_start_q;
	logic [COUNTER_BITS-1:0] edge_cap_q;
	logic [COUNTER_BITS-1:0] width_q;
	urc_pkg::phase_t         phase_q;
	logic                    await_q;
	logic                    toggle_q;
	logic                    saved_q;
	logic                    echo_prev_q;
	logic [urc_pkg::DIST_W-1:0] last_dist_q;

	// Per-tick results
	logic trig_q;
	logic busy_q;
	logic done_q;

	// Arithmetic datapath
	logic [urc_pkg::FACTOR_W-1:0] factor_q;
	logic [PROD_W-1:0]            prod_q;
	logic [LO_PROD_W-1:0]         acc_q;

	// Sequencer and output register
	logic [urc_pkg::STEP_W-1:0]    pc_q;
	logic [urc_pkg::STEP_W-1:0]    pc_d;
	urc_pkg::ctl_word_t            ctl;
	logic                          jump;
	logic                          m_valid_q;
	logic [urc_pkg::OUT_DATA_W-1:0] out_data_q;

	// Input fields
	logic                            start_in;
	logic                            echo_in;
	logic signed [urc_pkg::TEMP_W-1:0] temp_in;
	logic [urc_pkg::HUM_W-1:0]       hum_in;
	logic                            in_acc;

	assign start_in = s_axis_tdata[0];
	assign echo_in  = s_axis_tdata[1];
	assign temp_in  = s_axis_tdata[9:2];
	assign hum_in   = s_axis_tdata[16:10];

	assign ctl           = urc_pkg::ucode_rom(pc_q);
	assign s_axis_tready = (ctl.op == urc_pkg::OP_FETCH);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Echo edge capture
	logic                    edge_seen;
	logic [COUNTER_BITS-1:0] edge_cap_d;
	logic [COUNTER_BITS-1:0] width_d;
	logic                    toggle_d;
	logic                    await_d;

	always_comb begin
		edge_seen  = (echo_in != echo_prev_q);
		edge_cap_d = edge_cap_q;
		width_d    = width_q;
		toggle_d   = toggle_q;
		await_d    = await_q;
		if (edge_seen) begin
			if (!await_q) begin
				edge_cap_d = free_cnt_q;
			end else begin
				width_d  = free_cnt_q - edge_cap_q;
				toggle_d = ~toggle_q;
			end
			await_d = ~await_q;
		end
	end

	// Phase machine: start, trigger end and echo check fall through in one tick
	logic                    start_hit;
	logic [COUNTER_BITS-1:0] trig_start_d;
	logic                    saved_d;
	logic                    in_trig;
	logic                    trig_run;
	logic                    in_wait;
	logic                    finish;
	urc_pkg::phase_t         phase_d;

	always_comb begin
		start_hit    = (phase_q == urc_pkg::PH_IDLE) && start_in;
		trig_start_d = start_hit ? free_cnt_q : trig_start_q;
		saved_d      = start_hit ? toggle_d : saved_q;
		in_trig      = start_hit || (phase_q == urc_pkg::PH_TRIG);
		trig_run     = (free_cnt_q - trig_start_d) < COUNTER_BITS'(trig_ticks_q);
		in_wait      = (phase_q == urc_pkg::PH_WAIT) || (in_trig && !trig_run);
		finish       = in_wait && (toggle_d != saved_d);
		if (finish) begin
			phase_d = urc_pkg::PH_IDLE;
		end else if (in_wait) begin
			phase_d = urc_pkg::PH_WAIT;
		end else if (in_trig) begin
			phase_d = urc_pkg::PH_TRIG;
		end else begin
			phase_d = urc_pkg::PH_IDLE;
		end
	end

	// Tick outputs
	logic trig_d;
	logic busy_d;
	logic done_d;

	always_comb begin
		trig_d = in_trig && trig_run;
		busy_d = (phase_d != urc_pkg::PH_IDLE);
		done_d = finish;
	end

	// Sound speed factor from temperature and humidity
	logic [23:0] factor_full;

	always_comb begin
		factor_full = 24'(urc_pkg::SOUND_BASE)
			+ 24'(temp_in) * 24'(urc_pkg::TEMP_COEF)
			+ 24'(hum_in) * 24'(urc_pkg::HUM_COEF);
	end

	// Saturation check
	logic [CMP_W-1:0] prod_ext;
	logic             sat;

	always_comb begin
		prod_ext = CMP_W'(prod_q);
		sat      = prod_ext >= CMP_W'(urc_pkg::SAT_LIMIT);
	end

	// Reciprocal multiply: low half first, high half plus carried low part next
	logic [X_W-1:0]             x_val;
	logic [LO_PROD_W-1:0]       lo_prod;
	logic [SUM_W-1:0]           hi_sum;
	logic [urc_pkg::DIST_W-1:0] quo_val;

	always_comb begin
		x_val   = prod_ext[SAT_W-1:urc_pkg::PRE_SHIFT];
		lo_prod = LO_PROD_W'(x_val[LO_W-1:0]) * LO_PROD_W'(urc_pkg::RECIP_625);
		hi_sum  = SUM_W'(x_val[X_W-1:LO_W]) * SUM_W'(urc_pkg::RECIP_625)
			+ SUM_W'(acc_q >> LO_W);
		quo_val = hi_sum[QSH+urc_pkg::DIST_W-1:QSH];
	end

	// Sequencer condition and next step
	logic out_full;
	assign out_full = m_valid_q && !m_axis_tready;

	always_comb begin
		case (ctl.cond)
			urc_pkg::C_NONE:      jump = 1'b0;
			urc_pkg::C_NO_ACCEPT: jump = !in_acc;
			urc_pkg::C_NO_DONE:   jump = !done_q;
			urc_pkg::C_SAT:       jump = sat;
			urc_pkg::C_OUT_FULL:  jump = out_full;
			default:              jump = 1'b0;
		endcase
		if (jump) begin
			pc_d = ctl.target;
		end else if (ctl.last) begin
			pc_d = urc_pkg::STEP_FETCH;
		end else begin
			pc_d = pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= urc_pkg::STEP_FETCH;
		end else begin
			pc_q <= pc_d;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_ticks_q <= urc_pkg::TRIG_TICKS_RST;
			min_dist_q   <= urc_pkg::MIN_DIST_RST;
			max_dist_q   <= urc_pkg::MAX_DIST_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				urc_pkg::REG_TRIGGER_TICKS: trig_ticks_q <= cfg_data[urc_pkg::TICKS_W-1:0];
				urc_pkg::REG_MIN_DISTANCE:  min_dist_q   <= cfg_data;
				urc_pkg::REG_MAX_DISTANCE:  max_dist_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Tick state update on an accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_cnt_q   <= '0;
			trig_start_q <= '0;
			edge_cap_q   <= '0;
			width_q      <= '0;
			phase_q      <= urc_pkg::PH_IDLE;
			await_q      <= 1'b0;
			toggle_q     <= 1'b0;
			saved_q      <= 1'b0;
			echo_prev_q  <= 1'b0;
			trig_q       <= 1'b0;
			busy_q       <= 1'b0;
			done_q       <= 1'b0;
		end else if (in_acc) begin
			free_cnt_q   <= free_cnt_q + 1'b1;
			trig_start_q <= trig_start_d;
			edge_cap_q   <= edge_cap_d;
			width_q      <= width_d;
			phase_q      <= phase_d;
			await_q      <= await_d;
			toggle_q     <= toggle_d;
			saved_q      <= saved_d;
			echo_prev_q  <= echo_in;
			trig_q       <= trig_d;
			busy_q       <= busy_d;
			done_q       <= done_d;
		end
	end

	// Arithmetic registers: factor, product, low partial product
	always_ff @(posedge clk) begin
		case (ctl.op)
			urc_pkg::OP_FETCH: begin
				factor_q <= factor_full[urc_pkg::FACTOR_W-1:0];
			end
			urc_pkg::OP_MUL: begin
				prod_q <= PROD_W'(width_q) * PROD_W'(factor_q);
			end
			urc_pkg::OP_RLO: begin
				acc_q <= lo_prod;
			end
			default: ;
		endcase
	end

	// Last distance: saturated value or quotient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_dist_q <= '0;
		end else if (ctl.op == urc_pkg::OP_SAT && sat) begin
			last_dist_q <= urc_pkg::DIST_MAX;
		end else if (ctl.op == urc_pkg::OP_RHI) begin
			last_dist_q <= quo_val;
		end
	end

	// Output register
	logic out_load;
	logic in_rng;
	assign out_load = (ctl.op == urc_pkg::OP_EMIT) && !out_full;
	assign in_rng   = (last_dist_q >= min_dist_q) && (last_dist_q <= max_dist_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {4'b0, in_rng, last_dist_q, done_q, busy_q, trig_q};
		end
	end

`ifndef SYNTH
	// A tick is taken only once per program pass
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("tick accepted twice in one pass");

	// Reciprocal steps run only on products below the saturation limit
	a_recip_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == urc_pkg::OP_RLO) |-> !sat)
		else $error("reciprocal step on a saturating product");

	// A delivered distance ends the measurement
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && out_data_q[2]) |-> !out_data_q[1])
		else $error("done reported while still busy");

	// Trigger high only within a measurement
	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && out_data_q[0]) |-> out_data_q[1])
		else $error("trigger high while idle");
`endif

endmodule
